@@ rtl/core/dpwp_pkg.sv @@
// Shared constants, register map and item types for the depth pixel to world point block.
package dpwp_pkg;

    localparam int PIXEL_INDEX_BITS_DEF = 12;
    localparam int DEPTH_BITS_DEF       = 16;

    // Field and register widths
    localparam int COLOR_W   = 8;
    localparam int COORD_W   = 32;
    localparam int CENTER_W  = 16;
    localparam int INV_W     = 32;
    localparam int SCALE_W   = 24;
    localparam int ROT_W     = 16;
    localparam int TRANS_W   = 21;
    localparam int CFG_W     = 64;

    // Fixed-point shifts
    localparam int CENTER_FRAC  = 4;
    localparam int ZQ_SHIFT     = 8;
    localparam int RATIO_SHIFT  = 12;
    localparam int Z_FRAC_SHIFT = 16;
    localparam int WORLD_SHIFT  = 22;

    // Camera coordinates are clamped to +-2^CAM_LIMIT_SHIFT
    localparam int CAM_LIMIT_SHIFT = 45;
    localparam int CAM_W           = CAM_LIMIT_SHIFT + 2;
    localparam int CAM_Z_W         = 32;
    localparam int SUM_W           = 64;

    // Register map: 8-byte stride
    localparam int PADDR_W   = 6;
    localparam int ADDR_LSB  = 3;
    localparam int REG_IDX_W = PADDR_W - ADDR_LSB;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_OPTICAL_CENTER = 3'd0,
        REG_INVERSE_FOCAL  = 3'd1,
        REG_DEPTH_TO_MM    = 3'd2,
        REG_ROTATION_ROW0  = 3'd3,
        REG_ROTATION_ROW1  = 3'd4,
        REG_ROTATION_ROW2  = 3'd5,
        REG_TRANSLATION_MM = 3'd6
    } t_reg_idx;

    localparam logic [31:0]        OPTICAL_CENTER_RST = 32'd265819224;
    localparam logic [63:0]        INVERSE_FOCAL_RST  = 64'd138839112842884;
    localparam logic [SCALE_W-1:0] DEPTH_TO_MM_RST    = 24'd36409;
    localparam logic [63:0]        ROTATION_ROW0_RST  = 64'd16384;
    localparam logic [63:0]        ROTATION_ROW1_RST  = 64'd1073741824;
    localparam logic [63:0]        ROTATION_ROW2_RST  = 64'd70368744177664;
    localparam logic [62:0]        TRANSLATION_RST    = 63'd0;

    typedef struct packed {
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
    } t_color;

    typedef struct packed {
        logic [CENTER_W-1:0] center_col;
        logic [CENTER_W-1:0] center_row;
        logic [INV_W-1:0]    inv_fx;
        logic [INV_W-1:0]    inv_fy;
        logic [SCALE_W-1:0]  depth_scale;
    } t_proj_cfg;

    typedef struct packed {
        logic [2:0][2:0][ROT_W-1:0] rot;
        logic [2:0][TRANS_W-1:0]    trans;
    } t_xform_cfg;

    typedef struct packed {
        logic                       valid;
        logic signed [CAM_W-1:0]    cam_x;
        logic signed [CAM_W-1:0]    cam_y;
        logic [CAM_Z_W-1:0]         cam_z;
        t_color                     color;
    } t_cam_item;

endpackage

@@ rtl/core/dpwp_proj.sv @@
// Back-projection pipeline: depth scaling and pinhole camera coordinates, five stages.
module dpwp_proj #(
    parameter int PIXEL_INDEX_BITS = dpwp_pkg::PIXEL_INDEX_BITS_DEF,
    parameter int DEPTH_BITS       = dpwp_pkg::DEPTH_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [PIXEL_INDEX_BITS-1:0] i_column,
    input  logic [PIXEL_INDEX_BITS-1:0] i_row_index,
    input  logic [DEPTH_BITS-1:0]       i_depth_raw,
    input  dpwp_pkg::t_color            i_color,
    input  dpwp_pkg::t_proj_cfg         i_cfg,
    output dpwp_pkg::t_cam_item         o_item
);
    import dpwp_pkg::*;

    localparam int DU_W = ((PIXEL_INDEX_BITS + CENTER_FRAC) > CENTER_W ?
                           PIXEL_INDEX_BITS + CENTER_FRAC : CENTER_W) + 1;
    localparam int PX_W = DU_W + INV_W + 1;
    localparam int R_W  = PX_W - RATIO_SHIFT;
    localparam int ZP_W = DEPTH_BITS + SCALE_W;
    localparam int Z_W  = ZP_W - ZQ_SHIFT;
    localparam int ZH_W = Z_W - Z_FRAC_SHIFT;
    localparam int P_W  = R_W + ZH_W + 1;
    localparam int L_W  = R_W + Z_FRAC_SHIFT + 1;
    localparam int Q_W  = L_W - Z_FRAC_SHIFT;
    localparam int V_W  = P_W + 1;

    localparam logic [ZP_W-1:0]        ZQ_HALF = ZP_W'(1) << (ZQ_SHIFT - 1);
    localparam logic signed [PX_W-1:0] PX_HALF = PX_W'(1) << (RATIO_SHIFT - 1);
    localparam logic signed [L_W-1:0]  LO_HALF = L_W'(1) << (Z_FRAC_SHIFT - 1);
    localparam logic signed [V_W-1:0]  V_LIM   =
        {{(V_W - CAM_LIMIT_SHIFT - 1){1'b0}}, 1'b1, {CAM_LIMIT_SHIFT{1'b0}}};

    function automatic logic signed [CAM_W-1:0] clamp_cam(input logic signed [V_W-1:0] v);
        logic signed [V_W-1:0] c;
        c = v;
        if (v > V_LIM) begin
            c = V_LIM;
        end else if (v < -V_LIM) begin
            c = -V_LIM;
        end
        return c[CAM_W-1:0];
    endfunction

    // valid bits
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid, r_s5_valid;

    // stage 1
    logic [ZP_W-1:0]        r_s1_zprod;
    logic signed [DU_W-1:0] r_s1_dux, r_s1_duy;
    t_color                 r_s1_color;
    // stage 2
    logic [Z_W-1:0]         r_s2_zq8;
    logic signed [PX_W-1:0] r_s2_px, r_s2_py;
    t_color                 r_s2_color;
    // stage 3
    logic [Z_W-1:0]         r_s3_zq8;
    logic signed [R_W-1:0]  r_s3_rx, r_s3_ry;
    t_color                 r_s3_color;
    // stage 4
    logic [Z_W-1:0]         r_s4_zq8;
    logic signed [P_W-1:0]  r_s4_hx, r_s4_hy;
    logic signed [L_W-1:0]  r_s4_lx, r_s4_ly;
    t_color                 r_s4_color;
    // stage 5
    logic signed [CAM_W-1:0] r_s5_cam_x, r_s5_cam_y;
    logic [Z_W-1:0]          r_s5_zq8;
    t_color                  r_s5_color;

    logic signed [PX_W-1:0] n_px_rnd, n_py_rnd;
    logic [ZH_W-1:0]        n_zh;
    logic [Z_FRAC_SHIFT-1:0] n_zl;
    logic signed [L_W-1:0]  n_lx_rnd, n_ly_rnd;
    logic signed [Q_W-1:0]  n_lx_q, n_ly_q;
    logic signed [V_W-1:0]  n_vx, n_vy;

    always_comb begin
        n_px_rnd = r_s2_px + PX_HALF;
        n_py_rnd = r_s2_py + PX_HALF;
        n_zh     = r_s3_zq8[Z_W-1:Z_FRAC_SHIFT];
        n_zl     = r_s3_zq8[Z_FRAC_SHIFT-1:0];
        n_lx_rnd = r_s4_lx + LO_HALF;
        n_ly_rnd = r_s4_ly + LO_HALF;
        n_lx_q   = n_lx_rnd[L_W-1:Z_FRAC_SHIFT];
        n_ly_q   = n_ly_rnd[L_W-1:Z_FRAC_SHIFT];
        n_vx     = V_W'(r_s4_hx) + V_W'(n_lx_q);
        n_vy     = V_W'(r_s4_hy) + V_W'(n_ly_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else begin
            // zero depth carries no measurement: drop the item here
            r_s1_valid <= i_valid && (i_depth_raw != '0);
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_zprod <= ZP_W'(i_depth_raw) * ZP_W'(i_cfg.depth_scale);
        r_s1_dux   <= (DU_W'(i_column) << CENTER_FRAC) - DU_W'(i_cfg.center_col);
        r_s1_duy   <= (DU_W'(i_row_index) << CENTER_FRAC) - DU_W'(i_cfg.center_row);
        r_s1_color <= i_color;

        r_s2_zq8   <= Z_W'((r_s1_zprod + ZQ_HALF) >> ZQ_SHIFT);
        r_s2_px    <= r_s1_dux * $signed({1'b0, i_cfg.inv_fx});
        r_s2_py    <= r_s1_duy * $signed({1'b0, i_cfg.inv_fy});
        r_s2_color <= r_s1_color;

        r_s3_zq8   <= r_s2_zq8;
        r_s3_rx    <= n_px_rnd[PX_W-1:RATIO_SHIFT];
        r_s3_ry    <= n_py_rnd[PX_W-1:RATIO_SHIFT];
        r_s3_color <= r_s2_color;

        // split depth into high and low halves to keep the multipliers narrow
        r_s4_zq8   <= r_s3_zq8;
        r_s4_hx    <= r_s3_rx * $signed({1'b0, n_zh});
        r_s4_hy    <= r_s3_ry * $signed({1'b0, n_zh});
        r_s4_lx    <= r_s3_rx * $signed({1'b0, n_zl});
        r_s4_ly    <= r_s3_ry * $signed({1'b0, n_zl});
        r_s4_color <= r_s3_color;

        r_s5_cam_x <= clamp_cam(n_vx);
        r_s5_cam_y <= clamp_cam(n_vy);
        r_s5_zq8   <= r_s4_zq8;
        r_s5_color <= r_s4_color;
    end

    always_comb begin
        o_item.valid = r_s5_valid;
        o_item.cam_x = r_s5_cam_x;
        o_item.cam_y = r_s5_cam_y;
        o_item.cam_z = CAM_Z_W'(r_s5_zq8);
        o_item.color = r_s5_color;
    end

endmodule

@@ rtl/core/dpwp_xform.sv @@
// Rigid transform pipeline: rotation products, adder tree, rounding and saturation.
module dpwp_xform (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  dpwp_pkg::t_cam_item              i_item,
    input  dpwp_pkg::t_xform_cfg             i_cfg,
    output logic                             o_valid,
    output logic signed [dpwp_pkg::COORD_W-1:0] o_world_x,
    output logic signed [dpwp_pkg::COORD_W-1:0] o_world_y,
    output logic signed [dpwp_pkg::COORD_W-1:0] o_world_z,
    output logic [dpwp_pkg::COLOR_W-1:0]     o_out_blue,
    output logic [dpwp_pkg::COLOR_W-1:0]     o_out_green,
    output logic [dpwp_pkg::COLOR_W-1:0]     o_out_red
);
    import dpwp_pkg::*;

    localparam int Q_W = SUM_W - WORLD_SHIFT;
    localparam logic signed [SUM_W-1:0] SUM_HALF = SUM_W'(1) << (WORLD_SHIFT - 1);
    localparam logic signed [Q_W-1:0] Q_MAX =
        {{(Q_W - COORD_W + 1){1'b0}}, {(COORD_W - 1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN =
        {{(Q_W - COORD_W + 1){1'b1}}, {(COORD_W - 1){1'b0}}};

    logic r_s6_valid, r_s7_valid, r_s8_valid, r_out_valid;

    logic signed [SUM_W-1:0]   r_s6_prod [3][3];
    logic signed [SUM_W-1:0]   r_s6_trans [3];
    t_color                    r_s6_color;
    logic signed [SUM_W-1:0]   r_s7_pa [3];
    logic signed [SUM_W-1:0]   r_s7_pb [3];
    t_color                    r_s7_color;
    logic signed [SUM_W-1:0]   r_s8_sum [3];
    t_color                    r_s8_color;
    logic signed [COORD_W-1:0] r_world [3];
    t_color                    r_out_color;

    logic signed [CAM_W-1:0]   n_cam [3];
    logic signed [SUM_W-1:0]   n_prod [3][3];
    logic signed [SUM_W-1:0]   n_trans [3];
    logic signed [SUM_W-1:0]   n_rnd [3];
    logic signed [Q_W-1:0]     n_q [3];
    logic signed [COORD_W-1:0] n_world [3];

    always_comb begin
        n_cam[0] = i_item.cam_x;
        n_cam[1] = i_item.cam_y;
        n_cam[2] = CAM_W'(i_item.cam_z);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_prod[i][j] = $signed(i_cfg.rot[i][j]) * n_cam[j];
            end
            n_trans[i] = SUM_W'($signed(i_cfg.trans[i])) <<< WORLD_SHIFT;
        end
    end

    // round half up, then saturate to signed 32 bits
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_rnd[i] = r_s8_sum[i] + SUM_HALF;
            n_q[i]   = n_rnd[i][SUM_W-1:WORLD_SHIFT];
            if (n_q[i] > Q_MAX) begin
                n_world[i] = Q_MAX[COORD_W-1:0];
            end else if (n_q[i] < Q_MIN) begin
                n_world[i] = Q_MIN[COORD_W-1:0];
            end else begin
                n_world[i] = n_q[i][COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_valid  <= 1'b0;
            r_s7_valid  <= 1'b0;
            r_s8_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s6_valid  <= i_item.valid;
            r_s7_valid  <= r_s6_valid;
            r_s8_valid  <= r_s7_valid;
            r_out_valid <= r_s8_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_s6_prod[i][j] <= n_prod[i][j];
            end
            r_s6_trans[i] <= n_trans[i];
            r_s7_pa[i]    <= r_s6_prod[i][0] + r_s6_prod[i][1];
            r_s7_pb[i]    <= r_s6_prod[i][2] + r_s6_trans[i];
            r_s8_sum[i]   <= r_s7_pa[i] + r_s7_pb[i];
            r_world[i]    <= n_world[i];
        end
        r_s6_color  <= i_item.color;
        r_s7_color  <= r_s6_color;
        r_s8_color  <= r_s7_color;
        r_out_color <= r_s8_color;
    end

    assign o_valid     = r_out_valid;
    assign o_world_x   = r_world[0];
    assign o_world_y   = r_world[1];
    assign o_world_z   = r_world[2];
    assign o_out_blue  = r_out_color.blue;
    assign o_out_green = r_out_color.green;
    assign o_out_red   = r_out_color.red;

endmodule

@@ rtl/core/depth_pixel_to_world_point.sv @@
// Top level: depth pixel to world point, register file and nine-stage pipeline.
// o_valid is the registered end of the stage chain: an accepted start passes through u_proj and then u_xform.
// Throughput: one item per clock; busy stays low, every pixel flows through the stage chain.
// A pixel with zero depth gives no strobe; other items leave in order, once each.
// Reset (synchronous, active low) clears all valid bits and loads register defaults.
module depth_pixel_to_world_point #(
    parameter int PIXEL_INDEX_BITS = dpwp_pkg::PIXEL_INDEX_BITS_DEF,
    parameter int DEPTH_BITS       = dpwp_pkg::DEPTH_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dpwp_pkg::PADDR_W-1:0]        paddr,
    input  logic [dpwp_pkg::CFG_W-1:0]          pwdata,
    output logic [dpwp_pkg::CFG_W-1:0]          prdata,
    output logic                                pready,
    // item input
    input  logic                                start,
    output logic                                busy,
    input  logic [PIXEL_INDEX_BITS-1:0]         i_column,
    input  logic [PIXEL_INDEX_BITS-1:0]         i_row_index,
    input  logic [DEPTH_BITS-1:0]               i_depth_raw,
    input  logic [dpwp_pkg::COLOR_W-1:0]        i_blue,
    input  logic [dpwp_pkg::COLOR_W-1:0]        i_green,
    input  logic [dpwp_pkg::COLOR_W-1:0]        i_red,
    // result output
    output logic                                o_valid,
    output logic signed [dpwp_pkg::COORD_W-1:0] o_world_x,
    output logic signed [dpwp_pkg::COORD_W-1:0] o_world_y,
    output logic signed [dpwp_pkg::COORD_W-1:0] o_world_z,
    output logic [dpwp_pkg::COLOR_W-1:0]        o_out_blue,
    output logic [dpwp_pkg::COLOR_W-1:0]        o_out_green,
    output logic [dpwp_pkg::COLOR_W-1:0]        o_out_red
);
    import dpwp_pkg::*;

    localparam int LATENCY = 9;

    logic [31:0]        r_optical_center;
    logic [63:0]        r_inverse_focal;
    logic [SCALE_W-1:0] r_depth_to_mm;
    logic [63:0]        r_rotation_row [3];
    logic [62:0]        r_translation_mm;

    t_reg_idx    reg_idx;
    logic        cfg_wr;
    t_proj_cfg   proj_cfg;
    t_xform_cfg  xform_cfg;
    t_color      in_color;
    t_cam_item   cam_item;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign reg_idx = t_reg_idx'(paddr[PADDR_W-1:ADDR_LSB]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_optical_center  <= OPTICAL_CENTER_RST;
            r_inverse_focal   <= INVERSE_FOCAL_RST;
            r_depth_to_mm     <= DEPTH_TO_MM_RST;
            r_rotation_row[0] <= ROTATION_ROW0_RST;
            r_rotation_row[1] <= ROTATION_ROW1_RST;
            r_rotation_row[2] <= ROTATION_ROW2_RST;
            r_translation_mm  <= TRANSLATION_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_OPTICAL_CENTER: r_optical_center  <= pwdata[31:0];
                REG_INVERSE_FOCAL:  r_inverse_focal   <= pwdata;
                REG_DEPTH_TO_MM:    r_depth_to_mm     <= pwdata[SCALE_W-1:0];
                REG_ROTATION_ROW0:  r_rotation_row[0] <= pwdata;
                REG_ROTATION_ROW1:  r_rotation_row[1] <= pwdata;
                REG_ROTATION_ROW2:  r_rotation_row[2] <= pwdata;
                REG_TRANSLATION_MM: r_translation_mm  <= pwdata[62:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_OPTICAL_CENTER: prdata = CFG_W'(r_optical_center);
            REG_INVERSE_FOCAL:  prdata = r_inverse_focal;
            REG_DEPTH_TO_MM:    prdata = CFG_W'(r_depth_to_mm);
            REG_ROTATION_ROW0:  prdata = r_rotation_row[0];
            REG_ROTATION_ROW1:  prdata = r_rotation_row[1];
            REG_ROTATION_ROW2:  prdata = r_rotation_row[2];
            REG_TRANSLATION_MM: prdata = CFG_W'(r_translation_mm);
            default:            prdata = '0;
        endcase
    end

    always_comb begin
        proj_cfg.center_col  = r_optical_center[CENTER_W-1:0];
        proj_cfg.center_row  = r_optical_center[2*CENTER_W-1:CENTER_W];
        proj_cfg.inv_fx      = r_inverse_focal[INV_W-1:0];
        proj_cfg.inv_fy      = r_inverse_focal[2*INV_W-1:INV_W];
        proj_cfg.depth_scale = r_depth_to_mm;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                xform_cfg.rot[i][j] = r_rotation_row[i][ROT_W*j +: ROT_W];
            end
            xform_cfg.trans[i] = r_translation_mm[TRANS_W*i +: TRANS_W];
        end
        in_color.blue  = i_blue;
        in_color.green = i_green;
        in_color.red   = i_red;
    end

    dpwp_proj #(
        .PIXEL_INDEX_BITS (PIXEL_INDEX_BITS),
        .DEPTH_BITS       (DEPTH_BITS)
    ) u_proj (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (start && !busy),
        .i_column    (i_column),
        .i_row_index (i_row_index),
        .i_depth_raw (i_depth_raw),
        .i_color     (in_color),
        .i_cfg       (proj_cfg),
        .o_item      (cam_item)
    );

    dpwp_xform u_xform (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (cam_item),
        .i_cfg       (xform_cfg),
        .o_valid     (o_valid),
        .o_world_x   (o_world_x),
        .o_world_y   (o_world_y),
        .o_world_z   (o_world_z),
        .o_out_blue  (o_out_blue),
        .o_out_green (o_out_green),
        .o_out_red   (o_out_red)
    );

    // a strobe only ever follows an accepted item with a measured depth
    a_strobe_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy && (i_depth_raw != '0), LATENCY))
        else $error("result strobe without a matching accepted item");

    a_color_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_blue == $past(i_blue, LATENCY)) &&
                    (o_out_green == $past(i_green, LATENCY)) &&
                    (o_out_red == $past(i_red, LATENCY)))
        else $error("color bytes out of step with coordinates");

    a_scale_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n && cfg_wr && (reg_idx == REG_DEPTH_TO_MM))
        |-> (r_depth_to_mm == $past(pwdata[SCALE_W-1:0])))
        else $error("depth scale register write lost");

endmodule

@@ bench/tb_depth_pixel_to_world_point.sv @@
// Self-checking bench for the depth pixel to world point block: projects each pixel and compares.
`timescale 1ns / 100ps

module tb_depth_pixel_to_world_point;
    import dpwp_pkg::*;

    localparam int     PIXEL_BITS       = PIXEL_INDEX_BITS_DEF;
    localparam int     DEPTH_BITS       = DEPTH_BITS_DEF;
    localparam int     RESET_CYCLES     = 12;
    localparam int     DRAIN_CYCLES     = 20;
    localparam int     RANDOM_PER_PHASE = 300;
    localparam int     CYCLE_LIMIT      = 200000;
    localparam longint CAM_LIMIT        = longint'(1) <<< CAM_LIMIT_SHIFT;
    localparam longint WORLD_MAX        = 64'sd2147483647;
    localparam longint WORLD_MIN        = -64'sd2147483648;
    // one past the last register; writes there must be dropped
    localparam logic [REG_IDX_W-1:0] UNMAPPED_IDX = '1;

    typedef enum int {
        SET_TYPICAL,
        SET_ALL_ONES,
        SET_CLAMP,
        SET_ZERO,
        SET_RANDOM
    } t_setting;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] column;
        logic [PIXEL_BITS-1:0] row_index;
        logic [DEPTH_BITS-1:0] depth;
        t_color                color;
    } t_depth_pixel;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        t_color                    color;
    } t_world_point;

    class t_world_point_checker;
        bit [CENTER_W-1:0] center_col;
        bit [CENTER_W-1:0] center_row;
        bit [INV_W-1:0]    inv_fx;
        bit [INV_W-1:0]    inv_fy;
        bit [SCALE_W-1:0]  depth_scale;
        bit [63:0]         rotation [3];
        bit [62:0]         translation;
        t_world_point      expected_points [$];
        int                errors;

        function new();
            errors = 0;
            set_reg(REG_OPTICAL_CENTER, 64'(OPTICAL_CENTER_RST));
            set_reg(REG_INVERSE_FOCAL, INVERSE_FOCAL_RST);
            set_reg(REG_DEPTH_TO_MM, 64'(DEPTH_TO_MM_RST));
            set_reg(REG_ROTATION_ROW0, ROTATION_ROW0_RST);
            set_reg(REG_ROTATION_ROW1, ROTATION_ROW1_RST);
            set_reg(REG_ROTATION_ROW2, ROTATION_ROW2_RST);
            set_reg(REG_TRANSLATION_MM, 64'(TRANSLATION_RST));
        endfunction

        function void set_reg(logic [REG_IDX_W-1:0] idx, logic [63:0] value);
            case (idx)
                REG_OPTICAL_CENTER: begin
                    center_col = value[15:0];
                    center_row = value[31:16];
                end
                REG_INVERSE_FOCAL: begin
                    inv_fx = value[31:0];
                    inv_fy = value[63:32];
                end
                REG_DEPTH_TO_MM:    depth_scale = value[SCALE_W-1:0];
                REG_ROTATION_ROW0:  rotation[0] = value;
                REG_ROTATION_ROW1:  rotation[1] = value;
                REG_ROTATION_ROW2:  rotation[2] = value;
                REG_TRANSLATION_MM: translation = value[62:0];
                default: ;
            endcase
        endfunction

        // add half, then floor shift
        function longint round_off(longint v, int sh);
            return (v + (longint'(1) <<< (sh - 1))) >>> sh;
        endfunction

        function longint camera_axis(logic [PIXEL_BITS-1:0] pix, bit [CENTER_W-1:0] center,
                                     bit [INV_W-1:0] inv, longint zq8);
            longint du, ratio, z_hi, z_lo, cam;
            du    = (longint'(pix) <<< CENTER_FRAC) - longint'(center);
            ratio = round_off(du * longint'(inv), RATIO_SHIFT);
            z_hi  = zq8 >>> Z_FRAC_SHIFT;
            z_lo  = zq8 - (z_hi <<< Z_FRAC_SHIFT);
            cam   = ratio * z_hi + round_off(ratio * z_lo, Z_FRAC_SHIFT);
            if (cam > CAM_LIMIT)
                cam = CAM_LIMIT;
            if (cam < -CAM_LIMIT)
                cam = -CAM_LIMIT;
            return cam;
        endfunction

        function t_world_point project_pixel(t_depth_pixel px);
            t_world_point              pt;
            longint                    zq8, sum, w;
            longint                    cam [3];
            logic signed [COORD_W-1:0] world [3];
            zq8    = round_off(longint'(px.depth) * longint'(depth_scale), ZQ_SHIFT);
            cam[0] = camera_axis(px.column, center_col, inv_fx, zq8);
            cam[1] = camera_axis(px.row_index, center_row, inv_fy, zq8);
            cam[2] = zq8;
            for (int i = 0; i < 3; i++) begin
                sum = longint'($signed(translation[TRANS_W*i +: TRANS_W])) <<< WORLD_SHIFT;
                for (int j = 0; j < 3; j++)
                    sum += longint'($signed(rotation[i][ROT_W*j +: ROT_W])) * cam[j];
                w = round_off(sum, WORLD_SHIFT);
                if (w > WORLD_MAX)
                    w = WORLD_MAX;
                if (w < WORLD_MIN)
                    w = WORLD_MIN;
                world[i] = w[COORD_W-1:0];
            end
            pt.x     = world[0];
            pt.y     = world[1];
            pt.z     = world[2];
            pt.color = px.color;
            return pt;
        endfunction

        // zero depth means no measurement, hence no point
        function void note_pixel(t_depth_pixel px);
            if (px.depth != 0)
                expected_points = {expected_points, project_pixel(px)};
        endfunction

        function void compare_field(string field, logic signed [32:0] want,
                                    logic signed [32:0] seen);
            if (seen !== want) begin
                errors++;
                $error("%s mismatch: expected %0d, actual %0d", field, want, seen);
            end
        endfunction

        function void check_point(t_world_point seen);
            t_world_point want;
            if (expected_points.size() == 0) begin
                errors++;
                $error("world point with no pixel pending: x %0d y %0d z %0d",
                       seen.x, seen.y, seen.z);
                return;
            end
            want = expected_points.pop_front();
            compare_field("world_x", 33'(want.x), 33'(seen.x));
            compare_field("world_y", 33'(want.y), 33'(seen.y));
            compare_field("world_z", 33'(want.z), 33'(seen.z));
            compare_field("out_blue", 33'(want.color.blue), 33'(seen.color.blue));
            compare_field("out_green", 33'(want.color.green), 33'(seen.color.green));
            compare_field("out_red", 33'(want.color.red), 33'(seen.color.red));
        endfunction

        function int pending();
            return expected_points.size();
        endfunction
    endclass

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        psel        = 1'b0;
    logic                        penable     = 1'b0;
    logic                        pwrite      = 1'b0;
    logic [PADDR_W-1:0]          paddr       = '0;
    logic [CFG_W-1:0]            pwdata      = '0;
    logic [CFG_W-1:0]            prdata;
    logic                        pready;
    logic                        start       = 1'b0;
    logic                        busy;
    logic [PIXEL_BITS-1:0]       i_column    = '0;
    logic [PIXEL_BITS-1:0]       i_row_index = '0;
    logic [DEPTH_BITS-1:0]       i_depth_raw = '0;
    logic [COLOR_W-1:0]          i_blue      = '0;
    logic [COLOR_W-1:0]          i_green     = '0;
    logic [COLOR_W-1:0]          i_red       = '0;
    logic                        o_valid;
    logic signed [COORD_W-1:0]   o_world_x;
    logic signed [COORD_W-1:0]   o_world_y;
    logic signed [COORD_W-1:0]   o_world_z;
    logic [COLOR_W-1:0]          o_out_blue;
    logic [COLOR_W-1:0]          o_out_green;
    logic [COLOR_W-1:0]          o_out_red;

    t_world_point_checker points;
    t_depth_pixel         pixel_queue [$];
    t_world_point         seen_point;
    int                   cycle_count = 0;
    t_setting             schedule [5] = '{SET_TYPICAL, SET_ALL_ONES, SET_CLAMP,
                                           SET_ZERO, SET_RANDOM};

    depth_pixel_to_world_point dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .start       (start),
        .busy        (busy),
        .i_column    (i_column),
        .i_row_index (i_row_index),
        .i_depth_raw (i_depth_raw),
        .i_blue      (i_blue),
        .i_green     (i_green),
        .i_red       (i_red),
        .o_valid     (o_valid),
        .o_world_x   (o_world_x),
        .o_world_y   (o_world_y),
        .o_world_z   (o_world_z),
        .o_out_blue  (o_out_blue),
        .o_out_green (o_out_green),
        .o_out_red   (o_out_red)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("depth_pixel_to_world_point regression: fail");
            $finish;
        end
    end

    // results cannot be held off: take every strobe as it comes
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid !== 1'b0) begin
            seen_point.x           = o_world_x;
            seen_point.y           = o_world_y;
            seen_point.z           = o_world_z;
            seen_point.color.blue  = o_out_blue;
            seen_point.color.green = o_out_green;
            seen_point.color.red   = o_out_red;
            points.check_point(seen_point);
        end
    end

    function automatic void queue_pixel(logic [PIXEL_BITS-1:0] u, logic [PIXEL_BITS-1:0] v,
                                        logic [DEPTH_BITS-1:0] d, logic [COLOR_W-1:0] b,
                                        logic [COLOR_W-1:0] g, logic [COLOR_W-1:0] r);
        t_depth_pixel px;
        px.column      = u;
        px.row_index   = v;
        px.depth       = d;
        px.color.blue  = b;
        px.color.green = g;
        px.color.red   = r;
        pixel_queue = {pixel_queue, px};
    endfunction

    function automatic void queue_corners();
        queue_pixel('0, '0, '1, '0, '1, '0);
        queue_pixel('1, '1, '1, '1, '0, '1);
        queue_pixel('1, '0, '1, COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom));
        queue_pixel('0, '1, '1, COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom));
        queue_pixel('1, '1, DEPTH_BITS'(1),
                    COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom));
        queue_pixel('0, '0, DEPTH_BITS'(1),
                    COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom));
        queue_pixel('1, '0, '0, COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom));
        queue_pixel(PIXEL_BITS'($urandom), PIXEL_BITS'($urandom),
                    DEPTH_BITS'(1) << (DEPTH_BITS - 1),
                    COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom));
    endfunction

    function automatic void queue_random_pixel();
        logic [DEPTH_BITS-1:0] d;
        int unsigned           pick;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            d = '0;
        else if (pick < 20)
            d = '1;
        else if (pick < 30)
            d = DEPTH_BITS'($urandom_range(1, 16));
        else
            d = DEPTH_BITS'($urandom);
        queue_pixel(PIXEL_BITS'($urandom), PIXEL_BITS'($urandom), d,
                    COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom));
    endfunction

    function automatic logic [63:0] random_rotation_row();
        logic [63:0] row;
        row[63:48] = 16'($urandom);
        for (int j = 0; j < 3; j++)
            row[ROT_W*j +: ROT_W] = ROT_W'($urandom_range(0, 32768) - 16384);
        return row;
    endfunction

    // drain the pixel queue in bursts separated by idle gaps
    task automatic send_pixels();
        t_depth_pixel px;
        int unsigned  burst;
        burst = 0;
        while (pixel_queue.size() > 0) begin
            if (burst == 0)
                burst = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            px = pixel_queue.pop_front();
            i_column    <= px.column;
            i_row_index <= px.row_index;
            i_depth_raw <= px.depth;
            i_blue      <= px.color.blue;
            i_green     <= px.color.green;
            i_red       <= px.color.red;
            start       <= 1'b1;
            @(posedge i_clk);
            while (busy)
                @(posedge i_clk);
            points.note_pixel(px);
            burst--;
            if (burst == 0 || pixel_queue.size() == 0) begin
                start <= 1'b0;
                burst = 0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, {ADDR_LSB{1'b0}}};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        points.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_setting(t_setting setting);
        logic [63:0] regs [REG_TRANSLATION_MM+1];
        case (setting)
            SET_TYPICAL: begin
                regs[REG_OPTICAL_CENTER] = {32'($urandom), 16'($urandom), 16'($urandom)};
                regs[REG_INVERSE_FOCAL]  = {32'($urandom_range(18641, 55924)),
                                            32'($urandom_range(18641, 55924))};
                regs[REG_DEPTH_TO_MM]    = {40'($urandom), 24'($urandom_range(0, 1 << 18))};
                regs[REG_ROTATION_ROW0]  = random_rotation_row();
                regs[REG_ROTATION_ROW1]  = random_rotation_row();
                regs[REG_ROTATION_ROW2]  = random_rotation_row();
                regs[REG_TRANSLATION_MM] = {$urandom, $urandom};
            end
            SET_ALL_ONES: begin
                foreach (regs[i])
                    regs[i] = '1;
            end
            SET_CLAMP: begin
                // camera x overflows its clamp; a unit rotation entry exposes the clamped value
                regs[REG_OPTICAL_CENTER] = {32'h0, 16'hFFFF, 16'h0000};
                regs[REG_INVERSE_FOCAL]  = '1;
                regs[REG_DEPTH_TO_MM]    = {40'h0, 24'hFFFFFF};
                regs[REG_ROTATION_ROW0]  = {16'h0, 16'h0000, 16'h0000, 16'h0001};
                regs[REG_ROTATION_ROW1]  = {16'hA5C3, 16'h0000, 16'hFFFF, 16'h0000};
                regs[REG_ROTATION_ROW2]  = {16'h0, 16'h7FFF, 16'h8000, 16'h7FFF};
                regs[REG_TRANSLATION_MM] = {1'b0, 21'h000000, 21'h100000, 21'h0FFFFF};
            end
            SET_ZERO: begin
                foreach (regs[i])
                    regs[i] = '0;
                regs[REG_TRANSLATION_MM] = {1'b1, 21'($urandom), 21'h0FFFFF, 21'h100000};
            end
            default: begin
                foreach (regs[i])
                    regs[i] = {$urandom, $urandom};
            end
        endcase
        for (int i = 0; i <= REG_TRANSLATION_MM; i++)
            write_reg(REG_IDX_W'(i), regs[i]);
        write_reg(UNMAPPED_IDX, {$urandom, $urandom});
    endtask

    // hold until every point is back, then allow for zero-depth items still in flight
    task automatic wait_for_idle();
        while (points.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        points = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pixels beside the optical center under the reset intrinsics, then bit patterns, a zero depth and a corner
        queue_pixel(12'd325, 12'd253, 16'd1800, 8'h10, 8'h20, 8'h30);
        queue_pixel(12'd326, 12'd254, 16'd1800, 8'h01, 8'h02, 8'h03);
        queue_pixel(12'hAAA, 12'h555, 16'hAAAA, 8'hAA, 8'h55, 8'hAA);
        queue_pixel(12'h555, 12'hAAA, 16'h5555, 8'h55, 8'hAA, 8'h55);
        queue_pixel(12'h555, 12'hAAA, 16'h0000, 8'hFF, 8'hFF, 8'hFF);
        queue_pixel('1, '1, 16'h0001, 8'h00, 8'h00, 8'h00);
        queue_corners();
        repeat (RANDOM_PER_PHASE) queue_random_pixel();
        send_pixels();

        foreach (schedule[k]) begin
            wait_for_idle();
            load_setting(schedule[k]);
            queue_corners();
            repeat (RANDOM_PER_PHASE) queue_random_pixel();
            send_pixels();
        end

        wait_for_idle();
        if (points.errors == 0)
            $display("depth_pixel_to_world_point regression: pass");
        else
            $display("depth_pixel_to_world_point regression: fail");
        $finish;
    end

endmodule
